// File: hw/rtl/cte_pkg.sv
// ----------------------------------------------------------------------------
// cte_pkg
// Shared types, constants and tables for the civil time to epoch seconds
// pipeline.
// ----------------------------------------------------------------------------
package cte_pkg;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_STD_OFFSET  = 3'd0,
    CFG_DST_OFFSET  = 3'd1,
    CFG_DST_ENABLED = 3'd2,
    CFG_TIME_MAX    = 3'd3,
    CFG_TIME_MIN    = 3'd4
  } cfg_idx_e;

  // Floor division by 3 and by 25 through reciprocal multiplication.
  localparam logic [31:0] Div3Magic  = 32'hAAAA_AAAB;  // ceil(2^33 / 3)
  localparam int unsigned Div3Shift  = 33;
  localparam logic [31:0] Div25Magic = 32'h51EB_851F;  // ceil(2^35 / 25)
  localparam int unsigned Div25Shift = 35;

  // Biases that move signed operands into the range of the unsigned dividers.
  localparam logic signed [31:0] Div3Bias  = 32'sd805306368;  // 3 * 2^28
  localparam logic signed [30:0] Div3Off   = 31'sd268435456;  // 2^28
  localparam logic signed [30:0] Div25Bias = 31'sd419430400;  // 25 * 2^24
  localparam logic signed [25:0] Div25Off  = 26'sd16777216;   // 2^24

  localparam logic signed [33:0] YearBase      = 34'sd1900;
  localparam logic signed [44:0] DaysPerEra    = 45'sd146097;
  localparam logic signed [45:0] DaysYear0Unix = 46'sd719528;

  typedef struct packed {
    logic signed [31:0] year_offset;
    logic signed [31:0] month;
    logic signed [31:0] day_of_month;
    logic signed [31:0] hour;
    logic signed [31:0] minute;
    logic signed [31:0] second;
    logic               dst_request;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] epoch_seconds;
    logic               range_error;
    logic               dst_applied;
  } out_item_t;

  typedef struct packed {
    logic signed [17:0] std_offset;
    logic signed [17:0] dst_offset;
    logic               dst_enabled;
    logic signed [63:0] time_max;
    logic signed [63:0] time_min;
  } cfg_t;

  // Item after the month and era split.
  typedef struct packed {
    logic signed [25:0] era;
    logic [8:0]         yoe;
    logic [3:0]         mon;
    logic signed [31:0] mday;
    logic signed [44:0] hms;
    logic               dst;
  } split_t;

  // Item after the day count has been scaled to seconds.
  typedef struct packed {
    logic signed [63:0] day_secs;
    logic signed [44:0] hms;
    logic               dst;
  } days_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/civil_time_to_epoch_seconds.sv
// Each accepted item passes through nine register stages, the last one being
// the output register.
// Throughput: one item per cycle while out_stall_i is low; every stage holds an
// item, and a stage takes a new one whenever it is empty or its item moves on.
// Reset clears all stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// civil_time_to_epoch_seconds
// Converts a broken-down civil time to signed seconds since the 1970 epoch,
// with a standard or daylight zone offset and a bounds check.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_seconds (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cte_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cte_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_we_i,
  input  logic [cte_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [cte_pkg::CfgDataW-1:0]        cfg_data_i
);

  cte_pkg::cfg_t   cfg_q;
  logic            split_rdy;
  logic            split_vld;
  cte_pkg::split_t split_item;
  logic            days_rdy;
  logic            days_vld;
  cte_pkg::days_t  days_item;
  logic            bound_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.std_offset  <= '0;
      cfg_q.dst_offset  <= '0;
      cfg_q.dst_enabled <= 1'b0;
      cfg_q.time_max    <= {1'b0, {63{1'b1}}};
      cfg_q.time_min    <= {1'b1, {63{1'b0}}};
    end else if (cfg_we_i) begin
      case (cte_pkg::cfg_idx_e'(cfg_idx_i))
        cte_pkg::CFG_STD_OFFSET:  cfg_q.std_offset  <= cfg_data_i[17:0];
        cte_pkg::CFG_DST_OFFSET:  cfg_q.dst_offset  <= cfg_data_i[17:0];
        cte_pkg::CFG_DST_ENABLED: cfg_q.dst_enabled <= cfg_data_i[0];
        cte_pkg::CFG_TIME_MAX:    cfg_q.time_max    <= cfg_data_i;
        cte_pkg::CFG_TIME_MIN:    cfg_q.time_min    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cte_split u_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_valid_i),
    .rdy_o  (split_rdy),
    .item_i (in_item_i),
    .vld_o  (split_vld),
    .rdy_i  (days_rdy),
    .item_o (split_item)
  );

  cte_days u_days (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (split_vld),
    .rdy_o  (days_rdy),
    .item_i (split_item),
    .vld_o  (days_vld),
    .rdy_i  (bound_rdy),
    .item_o (days_item)
  );

  cte_bound u_bound (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .vld_i  (days_vld),
    .rdy_o  (bound_rdy),
    .item_i (days_item),
    .vld_o  (out_valid_o),
    .rdy_i  (!out_stall_i),
    .item_o (out_item_o)
  );

  assign in_stall_o = !split_rdy;

endmodule

// File: hw/rtl/cte_split.sv
// ----------------------------------------------------------------------------
// cte_split
// Four stages: folds the month into the year and splits the year into a
// 400-year era and the year of era, both with floor semantics.
// ----------------------------------------------------------------------------
module cte_split (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  output logic              rdy_o,
  input  cte_pkg::in_item_t item_i,
  output logic              vld_o,
  input  logic              rdy_i,
  output cte_pkg::split_t   item_o
);

  logic go1, go2, go3, go4;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;

  // Stage 1 signals.
  logic signed [31:0] m4;
  logic [31:0]        u3_full;
  logic signed [44:0] hms;
  logic [62:0]        s1_prod_q;
  logic [30:0]        s1_u3_q;
  logic [1:0]         s1_mlo_q;
  logic signed [31:0] s1_yoff_q;
  logic signed [31:0] s1_mday_q;
  logic signed [44:0] s1_hms_q;
  logic               s1_dst_q;

  // Stage 2 signals.
  logic [29:0]        q3;
  logic [30:0]        r3_full;
  logic signed [30:0] q12;
  logic signed [33:0] year;
  logic signed [30:0] y16;
  logic [30:0]        u25_full;
  logic [29:0]        s2_u25_q;
  logic [3:0]         s2_ylo_q;
  logic [3:0]         s2_mon_q;
  logic signed [31:0] s2_mday_q;
  logic signed [44:0] s2_hms_q;
  logic               s2_dst_q;

  // Stage 3 signals.
  logic [60:0]        s3_prod_q;
  logic [29:0]        s3_u25_q;
  logic [3:0]         s3_ylo_q;
  logic [3:0]         s3_mon_q;
  logic signed [31:0] s3_mday_q;
  logic signed [44:0] s3_hms_q;
  logic               s3_dst_q;

  // Stage 4 signals.
  logic [24:0]        q25;
  logic [29:0]        r25_full;
  cte_pkg::split_t    s4_q;

  // A stage loads when it is empty or when its content moves on.
  assign go4   = !s4_v_q || rdy_i;
  assign go3   = !s3_v_q || go4;
  assign go2   = !s2_v_q || go3;
  assign go1   = !s1_v_q || go2;
  assign rdy_o = go1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (go1) s1_v_q <= vld_i;
      if (go2) s2_v_q <= s1_v_q;
      if (go3) s3_v_q <= s2_v_q;
      if (go4) s4_v_q <= s3_v_q;
    end
  end

  // Stage 1: floor(month / 4) is biased to a positive value and multiplied
  // by the reciprocal of 3. The time of day is reduced to seconds.
  always_comb begin
    m4      = item_i.month >>> 2;
    u3_full = 32'(m4 + cte_pkg::Div3Bias);
    hms     = 45'(item_i.second)
            + (45'(item_i.minute) <<< 6) - (45'(item_i.minute) <<< 2)
            + (45'(item_i.hour) <<< 11) + (45'(item_i.hour) <<< 10)
            + (45'(item_i.hour) <<< 9) + (45'(item_i.hour) <<< 4);
  end

  always_ff @(posedge clk_i) begin
    if (go1) begin
      s1_prod_q <= 63'(u3_full[30:0]) * 63'(cte_pkg::Div3Magic);
      s1_u3_q   <= u3_full[30:0];
      s1_mlo_q  <= item_i.month[1:0];
      s1_yoff_q <= item_i.year_offset;
      s1_mday_q <= item_i.day_of_month;
      s1_hms_q  <= hms;
      s1_dst_q  <= item_i.dst_request;
    end
  end

  // Stage 2: the month index and the folded year, then the year is
  // divided by 16 and biased for the division by 25.
  always_comb begin
    q3       = s1_prod_q[62:cte_pkg::Div3Shift];
    r3_full  = s1_u3_q - (31'(q3) + (31'(q3) << 1));
    q12      = $signed({1'b0, q3}) - cte_pkg::Div3Off;
    year     = 34'(s1_yoff_q) + 34'(q12) + cte_pkg::YearBase;
    y16      = 31'(year >>> 4);
    u25_full = 31'(y16 + cte_pkg::Div25Bias);
  end

  always_ff @(posedge clk_i) begin
    if (go2) begin
      s2_u25_q  <= u25_full[29:0];
      s2_ylo_q  <= year[3:0];
      s2_mon_q  <= {r3_full[1:0], s1_mlo_q};
      s2_mday_q <= s1_mday_q;
      s2_hms_q  <= s1_hms_q;
      s2_dst_q  <= s1_dst_q;
    end
  end

  // Stage 3: reciprocal multiplication for the division by 25.
  always_ff @(posedge clk_i) begin
    if (go3) begin
      s3_prod_q <= 61'(s2_u25_q) * 61'(cte_pkg::Div25Magic);
      s3_u25_q  <= s2_u25_q;
      s3_ylo_q  <= s2_ylo_q;
      s3_mon_q  <= s2_mon_q;
      s3_mday_q <= s2_mday_q;
      s3_hms_q  <= s2_hms_q;
      s3_dst_q  <= s2_dst_q;
    end
  end

  // Stage 4: era and year of era; the year of era is the remainder of the
  // division by 25 times 16 plus the low four bits of the year.
  always_comb begin
    q25      = s3_prod_q[59:cte_pkg::Div25Shift];
    r25_full = s3_u25_q - ((30'(q25) << 4) + (30'(q25) << 3) + 30'(q25));
  end

  always_ff @(posedge clk_i) begin
    if (go4) begin
      s4_q.era  <= $signed({1'b0, q25}) - cte_pkg::Div25Off;
      s4_q.yoe  <= {r25_full[4:0], s3_ylo_q};
      s4_q.mon  <= s3_mon_q;
      s4_q.mday <= s3_mday_q;
      s4_q.hms  <= s3_hms_q;
      s4_q.dst  <= s3_dst_q;
    end
  end

  assign vld_o  = s4_v_q;
  assign item_o = s4_q;

  a_mon_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (s2_mon_q <= 4'd11))
    else $error("month index out of range after folding");

  a_yoe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |-> (s4_q.yoe <= 9'd399))
    else $error("year of era out of range");

  a_era_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |-> (s4_q.era >= -26'sd6000000 && s4_q.era <= 26'sd6000000))
    else $error("era outside the reachable range");

endmodule

// File: hw/rtl/cte_days.sv
// ----------------------------------------------------------------------------
// cte_days
// Three stages: day of era from the year of era and month, day number
// relative to the epoch, and its scaling to seconds.
// ----------------------------------------------------------------------------
module cte_days (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  output logic            rdy_o,
  input  cte_pkg::split_t item_i,
  output logic            vld_o,
  input  logic            rdy_i,
  output cte_pkg::days_t  item_o
);

  logic go1, go2, go3;
  logic s1_v_q, s2_v_q, s3_v_q;

  logic [17:0]        yoe365;
  logic [7:0]         leaps4;
  logic [1:0]         cent;
  logic               leap;
  logic [17:0]        doe;
  logic signed [44:0] s1_era_days_q;
  logic [17:0]        s1_doe_q;
  logic signed [32:0] s1_mday_m1_q;
  logic signed [44:0] s1_hms_q;
  logic               s1_dst_q;

  logic signed [45:0] s2_days_q;
  logic signed [44:0] s2_hms_q;
  logic               s2_dst_q;

  logic signed [63:0] days64;
  cte_pkg::days_t     s3_q;

  assign go3   = !s3_v_q || rdy_i;
  assign go2   = !s2_v_q || go3;
  assign go1   = !s1_v_q || go2;
  assign rdy_o = go1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (go1) s1_v_q <= vld_i;
      if (go2) s2_v_q <= s1_v_q;
      if (go3) s3_v_q <= s2_v_q;
    end
  end

  // Stage 1: days of the era before the month. Year zero of an era is a
  // leap year; the other century years are not.
  always_comb begin
    yoe365 = (18'(item_i.yoe) << 8) + (18'(item_i.yoe) << 6) + (18'(item_i.yoe) << 5)
           + (18'(item_i.yoe) << 3) + (18'(item_i.yoe) << 2) + 18'(item_i.yoe);
    leaps4 = 8'((10'(item_i.yoe) + 10'd3) >> 2);
    cent   = 2'(item_i.yoe > 9'd100) + 2'(item_i.yoe > 9'd200) + 2'(item_i.yoe > 9'd300);
    leap   = (item_i.mon > 4'd1) && (item_i.yoe[1:0] == 2'b00)
          && (item_i.yoe != 9'd100) && (item_i.yoe != 9'd200) && (item_i.yoe != 9'd300);
    doe    = yoe365 + 18'(leaps4) - 18'(cent)
           + 18'(cte_pkg::days_before_month(item_i.mon)) + 18'(leap);
  end

  always_ff @(posedge clk_i) begin
    if (go1) begin
      s1_era_days_q <= 45'(item_i.era) * cte_pkg::DaysPerEra;
      s1_doe_q      <= doe;
      s1_mday_m1_q  <= 33'(item_i.mday) - 33'sd1;
      s1_hms_q      <= item_i.hms;
      s1_dst_q      <= item_i.dst;
    end
  end

  // Stage 2: day number counted from the epoch.
  always_ff @(posedge clk_i) begin
    if (go2) begin
      s2_days_q <= 46'(s1_era_days_q) + $signed(46'(s1_doe_q)) + 46'(s1_mday_m1_q)
                 - cte_pkg::DaysYear0Unix;
      s2_hms_q  <= s1_hms_q;
      s2_dst_q  <= s1_dst_q;
    end
  end

  // Stage 3: times 86400 as a sum of shifted copies.
  assign days64 = 64'(s2_days_q);

  always_ff @(posedge clk_i) begin
    if (go3) begin
      s3_q.day_secs <= (days64 <<< 16) + (days64 <<< 14) + (days64 <<< 12)
                     + (days64 <<< 8) + (days64 <<< 7);
      s3_q.hms      <= s2_hms_q;
      s3_q.dst      <= s2_dst_q;
    end
  end

  assign vld_o  = s3_v_q;
  assign item_o = s3_q;

endmodule

// File: hw/rtl/cte_bound.sv
// ----------------------------------------------------------------------------
// cte_bound
// Two stages: adds the time of day and the zone offset, then checks both
// sums against the bounds. The second stage is the output register.
// ----------------------------------------------------------------------------
module cte_bound (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cte_pkg::cfg_t      cfg_i,
  input  logic               vld_i,
  output logic               rdy_o,
  input  cte_pkg::days_t     item_i,
  output logic               vld_o,
  input  logic               rdy_i,
  output cte_pkg::out_item_t item_o
);

  logic go1, go2;
  logic s1_v_q, s2_v_q;

  logic               use_dst;
  logic signed [17:0] offset;
  logic signed [63:0] s1_t_q;
  logic signed [63:0] s1_t_off_q;
  logic               s1_dst_q;

  logic               err;
  cte_pkg::out_item_t s2_q;

  assign go2   = !s2_v_q || rdy_i;
  assign go1   = !s1_v_q || go2;
  assign rdy_o = go1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (go1) s1_v_q <= vld_i;
      if (go2) s2_v_q <= s1_v_q;
    end
  end

  always_comb begin
    use_dst = cfg_i.dst_enabled && item_i.dst;
    offset  = use_dst ? cfg_i.dst_offset : cfg_i.std_offset;
  end

  always_ff @(posedge clk_i) begin
    if (go1) begin
      s1_t_q     <= item_i.day_secs + 64'(item_i.hms);
      s1_t_off_q <= item_i.day_secs + 64'(item_i.hms) + 64'(offset);
      s1_dst_q   <= use_dst;
    end
  end

  // The sum is checked both before and after the offset is applied.
  assign err = (s1_t_q > $signed(cfg_i.time_max)) || (s1_t_q < $signed(cfg_i.time_min))
            || (s1_t_off_q > $signed(cfg_i.time_max))
            || (s1_t_off_q < $signed(cfg_i.time_min));

  always_ff @(posedge clk_i) begin
    if (go2) begin
      s2_q.epoch_seconds <= err ? '1 : s1_t_off_q;
      s2_q.range_error   <= err;
      s2_q.dst_applied   <= s1_dst_q && !err;
    end
  end

  assign vld_o  = s2_v_q;
  assign item_o = s2_q;

endmodule
